### sv/shi_pkg.sv
// Shared types, codes and constants for the slow-init handshake block.
`timescale 1ns / 1ps
`default_nettype none

package shi_pkg;

    localparam int unsigned CMD_W    = 2;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned TICK_W   = 16;
    localparam int unsigned CFG_W    = 16;
    localparam int unsigned CFG_IDX_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_START = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_BYTE  = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_IDLE        = 3'd0,
        ST_BUSY        = 3'd1,
        ST_SUCCESS     = 3'd2,
        ST_NO_SYNC     = 3'd3,
        ST_BAD_KEYS    = 3'd4,
        ST_BAD_TITLE   = 3'd5,
        ST_SHORT_BLOCK = 3'd6
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BIT_TIME = 2'd0,
        CFG_IDLE     = 2'd1,
        CFG_SYNC_LIM = 2'd2,
        CFG_ADDRESS  = 2'd3
    } cfg_idx_t;

    localparam logic [BYTE_W-1:0] SYNC_BYTE  = 8'h55;
    localparam logic [BYTE_W-1:0] KEY_ONE    = 8'h52;
    localparam logic [BYTE_W-1:0] KEY_TWO    = 8'h80;
    localparam logic [BYTE_W-1:0] ACK_BYTE   = 8'h7F;
    localparam logic [BYTE_W-1:0] TITLE_BYTE = 8'hA0;

    localparam logic [TICK_W-1:0] BIT_TIME_RESET = 16'd200;
    localparam logic [TICK_W-1:0] IDLE_RESET     = 16'd2000;
    localparam logic [BYTE_W-1:0] SYNC_LIM_RESET = 8'd12;
    localparam logic [BYTE_W-1:0] ADDRESS_RESET  = 8'h62;

endpackage

`default_nettype wire

### sv/shi_item_if.sv
// Input and result channel interfaces of the slow-init handshake block.
`timescale 1ns / 1ps
`default_nettype none

interface shi_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] rx_byte;

    modport source (output valid, output command, output rx_byte, input ready);
    modport sink   (input valid, input command, input rx_byte, output ready);
endinterface

interface shi_result_if;
    logic       valid;
    logic       ready;
    logic       line_level;
    logic       send_valid;
    logic [7:0] send_byte;
    logic       id_valid;
    logic [7:0] id_byte;
    logic [2:0] status;
    logic [7:0] check_high;
    logic [7:0] check_low;

    modport source (
        output valid, output line_level, output send_valid, output send_byte,
        output id_valid, output id_byte, output status, output check_high,
        output check_low, input ready
    );
    modport sink (
        input valid, input line_level, input send_valid, input send_byte,
        input id_valid, input id_byte, input status, input check_high,
        input check_low, output ready
    );
endinterface

`default_nettype wire

### sv/slow_init_handshake.sv
// Slow-init handshake master: 5-baud address, sync/key check, ID block read.
// Every accepted item (start, tick or received byte) yields exactly one result,
// registered in the cycle after it is accepted. The handshake state and the
// result register update in the same edge, so an item is taken every cycle as
// long as the result register is empty or being drained: one item per cycle.
// Configuration registers are plain writes by index and take effect on the
// next item; write them only while no result is pending.
`timescale 1ns / 1ps
`default_nettype none

module slow_init_handshake (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [shi_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [shi_pkg::CFG_W-1:0]   cfg_data,
    shi_item_if.sink                         item,
    shi_result_if.source                     result
);
    import shi_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE, PH_HOLD, PH_BITS, PH_SYNC, PH_KEY1, PH_KEY2,
        PH_ECHO, PH_LEN, PH_TITLE, PH_ID, PH_DONE
    } phase_t;

    // configuration
    logic [TICK_W-1:0] bit_time_reg;
    logic [TICK_W-1:0] idle_reg;
    logic [BYTE_W-1:0] sync_lim_reg;
    logic [BYTE_W-1:0] address_reg;

    // handshake state
    phase_t            phase_reg, phase_next;
    logic [TICK_W-1:0] tick_reg, tick_next;
    logic [3:0]        bit_idx_reg, bit_idx_next;
    logic [BYTE_W-1:0] byte_cnt_reg, byte_cnt_next;
    logic [BYTE_W-1:0] blk_len_reg, blk_len_next;
    logic [BYTE_W-1:0] first_key_reg, first_key_next;
    logic [BYTE_W-1:0] chk_hi_reg, chk_hi_next;
    logic [BYTE_W-1:0] chk_lo_reg, chk_lo_next;
    status_t           code_reg, code_next;

    // result register
    logic              out_valid_reg, out_valid_next;
    logic              line_reg, line_next;
    logic              send_valid_reg, send_valid_next;
    logic              id_valid_reg, id_valid_next;
    logic [BYTE_W-1:0] id_byte_reg, id_byte_next;

    logic              in_xfer;
    logic [TICK_W:0]   tick_inc;
    logic [BYTE_W-1:0] byte_inc;
    logic [BYTE_W:0]   id_pos;
    logic [2:0]        addr_sel;

    assign item.ready = !out_valid_reg || result.ready;
    assign in_xfer    = item.valid && item.ready;
    assign tick_inc   = {1'b0, tick_reg} + 1'b1;
    assign byte_inc   = byte_cnt_reg + 1'b1;
    assign id_pos     = {1'b0, byte_cnt_reg} + 9'd2;

    always_comb
    begin
        phase_next      = phase_reg;
        tick_next       = tick_reg;
        bit_idx_next    = bit_idx_reg;
        byte_cnt_next   = byte_cnt_reg;
        blk_len_next    = blk_len_reg;
        first_key_next  = first_key_reg;
        chk_hi_next     = chk_hi_reg;
        chk_lo_next     = chk_lo_reg;
        code_next       = code_reg;
        send_valid_next = 1'b0;
        id_valid_next   = 1'b0;
        id_byte_next    = '0;

        unique case (cmd_t'(item.command))
            CMD_START:
            begin
                phase_next     = PH_HOLD;
                tick_next      = '0;
                bit_idx_next   = '0;
                byte_cnt_next  = '0;
                blk_len_next   = '0;
                first_key_next = '0;
                chk_hi_next    = '0;
                chk_lo_next    = '0;
                code_next      = ST_BUSY;
            end
            CMD_TICK:
            begin
                if (phase_reg == PH_HOLD)
                begin
                    if (tick_inc >= {1'b0, idle_reg})
                    begin
                        phase_next   = PH_BITS;
                        bit_idx_next = '0;
                        tick_next    = '0;
                    end
                    else
                    begin
                        tick_next = tick_inc[TICK_W-1:0];
                    end
                end
                else if (phase_reg == PH_BITS)
                begin
                    if (tick_inc >= {1'b0, bit_time_reg})
                    begin
                        tick_next = '0;
                        // stop bit done: start listening for sync
                        if (bit_idx_reg >= 4'd9)
                        begin
                            phase_next    = PH_SYNC;
                            byte_cnt_next = '0;
                            bit_idx_next  = '0;
                        end
                        else
                        begin
                            bit_idx_next = bit_idx_reg + 4'd1;
                        end
                    end
                    else
                    begin
                        tick_next = tick_inc[TICK_W-1:0];
                    end
                end
            end
            CMD_BYTE:
            begin
                case (phase_reg)
                    PH_SYNC:
                    begin
                        if (item.rx_byte == SYNC_BYTE)
                        begin
                            phase_next = PH_KEY1;
                        end
                        else
                        begin
                            byte_cnt_next = byte_inc;
                            if (byte_inc >= sync_lim_reg)
                            begin
                                phase_next = PH_DONE;
                                code_next  = ST_NO_SYNC;
                            end
                        end
                    end
                    PH_KEY1:
                    begin
                        first_key_next = item.rx_byte;
                        phase_next     = PH_KEY2;
                    end
                    PH_KEY2:
                    begin
                        if (first_key_reg != KEY_ONE || item.rx_byte != KEY_TWO)
                        begin
                            phase_next = PH_DONE;
                            code_next  = ST_BAD_KEYS;
                        end
                        else
                        begin
                            send_valid_next = 1'b1;
                            phase_next      = PH_ECHO;
                        end
                    end
                    PH_ECHO:
                    begin
                        phase_next = PH_LEN;
                    end
                    PH_LEN:
                    begin
                        blk_len_next = item.rx_byte;
                        phase_next   = PH_TITLE;
                    end
                    PH_TITLE:
                    begin
                        if (item.rx_byte != TITLE_BYTE)
                        begin
                            phase_next = PH_DONE;
                            code_next  = ST_BAD_TITLE;
                        end
                        else if (blk_len_reg < 8'd2)
                        begin
                            phase_next = PH_DONE;
                            code_next  = ST_SHORT_BLOCK;
                        end
                        else
                        begin
                            byte_cnt_next = '0;
                            phase_next    = PH_ID;
                        end
                    end
                    PH_ID:
                    begin
                        chk_hi_next = chk_lo_reg;
                        chk_lo_next = item.rx_byte;
                        // last two block bytes are check bytes, not reported
                        if (id_pos < {1'b0, blk_len_reg})
                        begin
                            id_valid_next = 1'b1;
                            id_byte_next  = item.rx_byte;
                        end
                        byte_cnt_next = byte_inc;
                        if (byte_inc >= blk_len_reg)
                        begin
                            phase_next = PH_DONE;
                            code_next  = ST_SUCCESS;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    // line level after this item: start bit low, data LSB first, stop high
    assign addr_sel = 3'(bit_idx_next - 4'd1);

    always_comb
    begin
        if (phase_next != PH_BITS)
            line_next = 1'b1;
        else if (bit_idx_next == 4'd0)
            line_next = 1'b0;
        else if (bit_idx_next >= 4'd9)
            line_next = 1'b1;
        else
            line_next = address_reg[addr_sel];
    end

    assign out_valid_next = in_xfer || (out_valid_reg && !result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_time_reg   <= BIT_TIME_RESET;
            idle_reg       <= IDLE_RESET;
            sync_lim_reg   <= SYNC_LIM_RESET;
            address_reg    <= ADDRESS_RESET;
            phase_reg      <= PH_IDLE;
            tick_reg       <= '0;
            bit_idx_reg    <= '0;
            byte_cnt_reg   <= '0;
            blk_len_reg    <= '0;
            first_key_reg  <= '0;
            chk_hi_reg     <= '0;
            chk_lo_reg     <= '0;
            code_reg       <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            line_reg       <= 1'b1;
            send_valid_reg <= 1'b0;
            id_valid_reg   <= 1'b0;
            id_byte_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_BIT_TIME: bit_time_reg <= cfg_data;
                    CFG_IDLE:     idle_reg     <= cfg_data;
                    CFG_SYNC_LIM: sync_lim_reg <= cfg_data[BYTE_W-1:0];
                    CFG_ADDRESS:  address_reg  <= cfg_data[BYTE_W-1:0];
                    default:      ;
                endcase
            end
            out_valid_reg <= out_valid_next;
            if (in_xfer)
            begin
                phase_reg      <= phase_next;
                tick_reg       <= tick_next;
                bit_idx_reg    <= bit_idx_next;
                byte_cnt_reg   <= byte_cnt_next;
                blk_len_reg    <= blk_len_next;
                first_key_reg  <= first_key_next;
                chk_hi_reg     <= chk_hi_next;
                chk_lo_reg     <= chk_lo_next;
                code_reg       <= code_next;
                line_reg       <= line_next;
                send_valid_reg <= send_valid_next;
                id_valid_reg   <= id_valid_next;
                id_byte_reg    <= id_byte_next;
            end
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.line_level = line_reg;
    assign result.send_valid = send_valid_reg;
    assign result.send_byte  = send_valid_reg ? ACK_BYTE : '0;
    assign result.id_valid   = id_valid_reg;
    assign result.id_byte    = id_byte_reg;
    assign result.status     = code_reg;
    assign result.check_high = chk_hi_reg;
    assign result.check_low  = chk_lo_reg;

endmodule

`default_nettype wire
